// ===== design/stt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stt_pkg
// Shared types and constants for the search transposition table.
// ----------------------------------------------------------------------------
package stt_pkg;

    // Slot count; must be a power of two (slot = low hash bits).
    localparam int ENTRY_COUNT = 65536;
    localparam int IDX_W       = $clog2(ENTRY_COUNT);

    localparam logic ACT_PROBE = 1'b0;
    localparam logic ACT_STORE = 1'b1;

    localparam logic [1:0] KIND_EXACT = 2'd0;
    localparam logic [1:0] KIND_LOWER = 2'd1;
    localparam logic [1:0] KIND_UPPER = 2'd2;

    typedef logic [IDX_W-1:0] t_idx;

    // Packed LSB-first order on the wire: last member is lowest.
    typedef struct packed {
        logic [3:0]         promo_piece;
        logic [5:0]         to_square;
        logic [5:0]         from_square;
        logic [1:0]         bound_kind;
        logic signed [18:0] score_in;
        logic signed [18:0] beta_bound;
        logic signed [18:0] alpha_bound;
        logic [6:0]         search_depth;
        logic [63:0]        hash_key;
    } t_in_fields;

    localparam int IN_FIELDS_W = $bits(t_in_fields);
    localparam int IN_TDATA_W  = ((IN_FIELDS_W + 7) / 8) * 8;

    typedef struct packed {
        logic       action;
        t_in_fields f;
    } t_req;

    typedef struct packed {
        logic [3:0]         promo;
        logic [5:0]         to_sq;
        logic [5:0]         from_sq;
        logic [1:0]         kind;
        logic [6:0]         depth;
        logic signed [18:0] score;
        logic [63:0]        hash;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef struct packed {
        logic               was_written;
        logic [3:0]         best_promo;
        logic [5:0]         best_to;
        logic [5:0]         best_from;
        logic signed [18:0] score_out;
        logic               score_usable;
        logic               hash_match;
    } t_result;

    localparam int RESULT_W    = $bits(t_result);
    localparam int OUT_TDATA_W = ((RESULT_W + 7) / 8) * 8;

endpackage

// ===== design/stt_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stt_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module stt_ram #(
    parameter int DEPTH  = 1024,
    parameter int WIDTH  = 8,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/stt_eval.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stt_eval
// Hit check, replacement decision and probe cutoff evaluation for one slot.
// ----------------------------------------------------------------------------
module stt_eval (
    input  stt_pkg::t_req    i_req,
    input  stt_pkg::t_entry  i_entry,
    output stt_pkg::t_result o_result,
    output logic             o_wr_en,
    output stt_pkg::t_entry  o_wr_entry
);
    import stt_pkg::*;

    logic hit;
    logic replace;
    logic deep_enough;
    logic usable;

    assign hit         = (i_entry.hash == i_req.f.hash_key);
    assign replace     = !hit || (i_entry.depth <= i_req.f.search_depth);
    assign deep_enough = (i_entry.depth >= i_req.f.search_depth);

    always_comb begin
        unique case (i_entry.kind)
            KIND_EXACT: usable = deep_enough;
            KIND_LOWER: usable = deep_enough && (i_entry.score >= i_req.f.beta_bound);
            KIND_UPPER: usable = deep_enough && (i_entry.score <= i_req.f.alpha_bound);
            default:    usable = 1'b0;
        endcase
    end

    always_comb begin
        o_wr_entry.hash    = i_req.f.hash_key;
        o_wr_entry.score   = i_req.f.score_in;
        o_wr_entry.depth   = i_req.f.search_depth;
        o_wr_entry.kind    = i_req.f.bound_kind;
        o_wr_entry.from_sq = i_req.f.from_square;
        o_wr_entry.to_sq   = i_req.f.to_square;
        o_wr_entry.promo   = i_req.f.promo_piece;
    end

    always_comb begin
        o_result = '0;
        o_wr_en  = 1'b0;
        if (i_req.action == ACT_STORE) begin
            o_wr_en              = replace;
            o_result.was_written = replace;
        end else if (hit) begin
            o_result.hash_match = 1'b1;
            o_result.best_from  = i_entry.from_sq;
            o_result.best_to    = i_entry.to_sq;
            o_result.best_promo = i_entry.promo;
            if (usable) begin
                o_result.score_usable = 1'b1;
                o_result.score_out    = i_entry.score;
            end
        end
    end

endmodule

// ===== design/search_transposition_table.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// search_transposition_table
// Direct-mapped, depth-preferred transposition table in one block RAM.
// ----------------------------------------------------------------------------
// Flow: an accepted request is read from RAM, then evaluated in S_EVAL; the result
// enters the output register once it is free (a held result keeps it full).
// Requests do not overlap: a new one is accepted only in S_IDLE, once the last one's
// RAM read, evaluation and write back to the same port pair are done.
// Reset: synchronous; a clearing pass writes zero to all ENTRY_COUNT slots
// while no request is accepted.
module search_transposition_table (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    // hash_key, search_depth, alpha_bound, beta_bound, score_in,
    // bound_kind, from_square, to_square, promo_piece
    input  logic [stt_pkg::IN_TDATA_W-1:0]     i_s_axis_tdata,
    // action
    input  logic                               i_s_axis_tuser,
    output logic                               o_m_axis_tvalid,
    input  logic                               i_m_axis_tready,
    // hash_match, score_usable, score_out, best_from, best_to,
    // best_promo, was_written
    output logic [stt_pkg::OUT_TDATA_W-1:0]    o_m_axis_tdata
);
    import stt_pkg::*;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_EVAL
    } t_state;

    t_state  r_state, n_state;
    t_idx    r_clr_idx, n_clr_idx;
    t_req    r_req, n_req;
    logic    r_out_valid, n_out_valid;
    t_result r_out_data, n_out_data;

    logic    in_accept;
    logic    out_free;
    logic    ram_we;
    t_idx    ram_waddr;
    t_entry  ram_wdata;
    t_entry  ram_rdata;
    t_idx    in_idx;
    t_in_fields in_fields;
    t_result ev_result;
    logic    ev_wr_en;
    t_entry  ev_wr_entry;

    assign in_fields       = t_in_fields'(i_s_axis_tdata[IN_FIELDS_W-1:0]);
    assign in_idx          = in_fields.hash_key[IDX_W-1:0];
    assign o_s_axis_tready = (r_state == S_IDLE);
    assign in_accept       = i_s_axis_tvalid && o_s_axis_tready;
    assign out_free        = !r_out_valid || i_m_axis_tready;

    stt_ram #(
        .DEPTH (ENTRY_COUNT),
        .WIDTH (ENTRY_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (in_accept),
        .i_raddr (in_idx),
        .o_rdata (ram_rdata)
    );

    stt_eval u_eval (
        .i_req      (r_req),
        .i_entry    (ram_rdata),
        .o_result   (ev_result),
        .o_wr_en    (ev_wr_en),
        .o_wr_entry (ev_wr_entry)
    );

    always_comb begin
        if (r_state == S_CLEAR) begin
            ram_we    = 1'b1;
            ram_waddr = r_clr_idx;
            ram_wdata = '0;
        end else begin
            ram_we    = (r_state == S_EVAL) && out_free && ev_wr_en;
            ram_waddr = r_req.f.hash_key[IDX_W-1:0];
            ram_wdata = ev_wr_entry;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_clr_idx   = r_clr_idx;
        n_req       = r_req;
        n_out_valid = r_out_valid && !i_m_axis_tready;
        n_out_data  = r_out_data;
        unique case (r_state)
            S_CLEAR: begin
                n_clr_idx = r_clr_idx + 1'b1;
                if (r_clr_idx == t_idx'(ENTRY_COUNT - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_accept) begin
                    n_req.action = i_s_axis_tuser;
                    n_req.f      = in_fields;
                    n_state      = S_EVAL;
                end
            end
            S_EVAL: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_data  = ev_result;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_idx   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_idx   <= n_clr_idx;
            r_out_valid <= n_out_valid;
        end
        r_req      <= n_req;
        r_out_data <= n_out_data;
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {{(OUT_TDATA_W - RESULT_W){1'b0}}, r_out_data};

    a_write_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> (r_state == S_CLEAR) || (r_state == S_EVAL))
        else $error("RAM write outside clear or evaluate phase");

    a_accept_eval: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> (r_state == S_EVAL))
        else $error("accepted request not evaluated next cycle");

    a_probe_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EVAL) && (r_req.action == ACT_PROBE) |-> !ram_we)
        else $error("probe request wrote the table");

    a_out_from_eval: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == S_EVAL))
        else $error("result appeared without an evaluated request");

    a_no_accept_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> !o_s_axis_tready)
        else $error("request taken during clearing pass");

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives probe and store requests into search_transposition_table over the
// input stream and checks every returned result against a shadow copy of the
// table. A short directed part covers the empty slot, field extremes, each
// bound kind, refused and forced replacement and the shallow-depth case; a
// random part then hits a small set of slots and tags so that probes match
// often, with idle gaps and stalls on both streams and one long output stall.
// ----------------------------------------------------------------------------
module testbench;

    import stt_pkg::*;

    // Shadow table: predicts each result and checks results in order.
    class tt_shadow;
        t_entry  slots [ENTRY_COUNT];
        t_result expected_q [$];
        int      mismatches;

        function new();
            foreach (slots[i]) slots[i] = '0;
            mismatches = 0;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void note_request(t_req r);
            t_idx    idx;
            t_entry  e;
            t_result res;
            logic    usable;
            idx = r.f.hash_key[IDX_W-1:0];
            e   = slots[idx];
            res = '0;
            if (r.action == ACT_STORE) begin
                if (e.hash != r.f.hash_key || e.depth <= r.f.search_depth) begin
                    e.hash    = r.f.hash_key;
                    e.score   = r.f.score_in;
                    e.depth   = r.f.search_depth;
                    e.kind    = r.f.bound_kind;
                    e.from_sq = r.f.from_square;
                    e.to_sq   = r.f.to_square;
                    e.promo   = r.f.promo_piece;
                    slots[idx] = e;
                    res.was_written = 1'b1;
                end
            end else if (e.hash == r.f.hash_key) begin
                res.hash_match = 1'b1;
                res.best_from  = e.from_sq;
                res.best_to    = e.to_sq;
                res.best_promo = e.promo;
                usable = 1'b0;
                if (e.depth >= r.f.search_depth) begin
                    case (e.kind)
                        KIND_EXACT: usable = 1'b1;
                        KIND_LOWER: usable = (e.score >= r.f.beta_bound);
                        KIND_UPPER: usable = (e.score <= r.f.alpha_bound);
                        default:    usable = 1'b0;
                    endcase
                end
                if (usable) begin
                    res.score_usable = 1'b1;
                    res.score_out    = e.score;
                end
            end
            expected_q = {expected_q, res};
        endfunction

        function void report(string what, longint want, longint got);
            mismatches++;
            if (mismatches <= 10)
                $display("%0t result error: %s expected %0d got %0d", $time, what, want, got);
        endfunction

        function void check_result(t_result act);
            t_result want;
            if (expected_q.size() == 0) begin
                report("result without request", 0, 1);
                return;
            end
            want = expected_q.pop_front();
            if (act.hash_match !== want.hash_match)
                report("hash_match", want.hash_match, act.hash_match);
            if (act.score_usable !== want.score_usable)
                report("score_usable", want.score_usable, act.score_usable);
            if (act.score_out !== want.score_out)
                report("score_out", longint'(want.score_out), longint'(act.score_out));
            if (act.best_from !== want.best_from)
                report("best_from", want.best_from, act.best_from);
            if (act.best_to !== want.best_to)
                report("best_to", want.best_to, act.best_to);
            if (act.best_promo !== want.best_promo)
                report("best_promo", want.best_promo, act.best_promo);
            if (act.was_written !== want.was_written)
                report("was_written", want.was_written, act.was_written);
        endfunction
    endclass

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_s_axis_tvalid;
    logic                   o_s_axis_tready;
    logic [IN_TDATA_W-1:0]  i_s_axis_tdata;
    logic                   i_s_axis_tuser;
    logic                   o_m_axis_tvalid;
    logic                   i_m_axis_tready;
    logic [OUT_TDATA_W-1:0] o_m_axis_tdata;

    tt_shadow          shadow;
    int                src_idle_pct;
    int                sink_idle_pct;
    bit                hold_sink;
    logic [63-IDX_W:0] tag_pool [4];
    t_idx              slot_pool [8];

    search_transposition_table DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    initial i_clk = 1'b0;
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // mostly short gaps, rarely a long one
    function automatic int gap_len(int pct);
        int r;
        r = $urandom_range(0, 99);
        if (r >= pct) return 0;
        if (r == 0) return $urandom_range(20, 60);
        return $urandom_range(1, 3);
    endfunction

    function automatic t_req make_req(logic act, logic [63:0] key, int depth, int alpha,
                                      int beta, int score, int kind, int from_sq,
                                      int to_sq, int promo);
        t_req r;
        r = '0;
        r.action         = act;
        r.f.hash_key     = key;
        r.f.search_depth = 7'(depth);
        r.f.alpha_bound  = 19'(alpha);
        r.f.beta_bound   = 19'(beta);
        r.f.score_in     = 19'(score);
        r.f.bound_kind   = 2'(kind);
        r.f.from_square  = 6'(from_sq);
        r.f.to_square    = 6'(to_sq);
        r.f.promo_piece  = 4'(promo);
        return r;
    endfunction

    function automatic int pick_score();
        case ($urandom_range(0, 5))
            0:       return -262144;
            1:       return 262143;
            2, 3:    return int'($urandom_range(0, 16)) - 8;
            default: return int'($urandom_range(0, 524287)) - 262144;
        endcase
    endfunction

    function automatic int pick_depth();
        if ($urandom_range(0, 3) == 0) return $urandom_range(0, 127);
        return $urandom_range(0, 6);
    endfunction

    function automatic t_req random_req();
        logic [63:0] key;
        if ($urandom_range(0, 9) == 0)
            key = {$urandom, $urandom};
        else
            key = {tag_pool[$urandom_range(0, 3)], slot_pool[$urandom_range(0, 7)]};
        return make_req($urandom_range(0, 1) ? ACT_STORE : ACT_PROBE, key, pick_depth(),
                        pick_score(), pick_score(), pick_score(), $urandom_range(0, 3),
                        $urandom_range(0, 63), $urandom_range(0, 63),
                        $urandom_range(0, 15));
    endfunction

    // called at a falling edge; returns at the falling edge after acceptance
    task automatic send_request(input t_req r);
        int n;
        n = gap_len(src_idle_pct);
        if (n > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (n) @(negedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= IN_TDATA_W'(r.f);
        i_s_axis_tuser  <= r.action;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        shadow.note_request(r);
        @(negedge i_clk);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready)
            shadow.check_result(t_result'(o_m_axis_tdata[RESULT_W-1:0]));
    end

    initial begin : result_sink
        int n;
        i_m_axis_tready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            if (hold_sink) begin
                i_m_axis_tready <= 1'b0;
                repeat (400) @(negedge i_clk);
                hold_sink = 1'b0;
            end
            n = gap_len(sink_idle_pct);
            if (n > 0) begin
                i_m_axis_tready <= 1'b0;
                repeat (n) @(negedge i_clk);
            end
            i_m_axis_tready <= 1'b1;
        end
    end

    initial begin : stimulus
        logic [63:0] key_a;
        logic [63:0] key_b;
        logic [63:0] key_c;
        int          idle_mix [4];
        shadow          = new();
        idle_mix        = '{0, 15, 40, 70};
        src_idle_pct    = 0;
        sink_idle_pct   = 0;
        hold_sink       = 1'b0;
        i_rst_n         = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        i_s_axis_tuser  = 1'b0;

        tag_pool[0] = '0;
        tag_pool[1] = '1;
        tag_pool[2] = (64 - IDX_W)'({$urandom, $urandom});
        tag_pool[3] = (64 - IDX_W)'({$urandom, $urandom});
        slot_pool[0] = '0;
        slot_pool[1] = '1;
        for (int i = 2; i < 8; i++) slot_pool[i] = t_idx'($urandom);

        key_a = {tag_pool[2], t_idx'(5)};
        key_b = {tag_pool[1], t_idx'(5)};
        key_c = {tag_pool[3], t_idx'(0)};

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // empty slot matches hash zero
        send_request(make_req(ACT_PROBE, 64'd0, 0, 0, 0, 0, 0, 0, 0, 0));
        send_request(make_req(ACT_PROBE, 64'd0, 5, 0, 0, 0, 0, 0, 0, 0));
        send_request(make_req(ACT_PROBE, key_c, 0, 0, 0, 0, 0, 0, 0, 0));
        // store, then refused and accepted replacement on the same hash
        send_request(make_req(ACT_STORE, key_a, 10, 0, 0, 262143, KIND_EXACT, 63, 63, 15));
        send_request(make_req(ACT_PROBE, key_a, 10, 0, 0, 0, 0, 0, 0, 0));
        send_request(make_req(ACT_PROBE, key_a, 11, 0, 0, 0, 0, 0, 0, 0));
        send_request(make_req(ACT_STORE, key_a, 9, 0, 0, 7, KIND_EXACT, 1, 2, 3));
        send_request(make_req(ACT_PROBE, key_a, 0, 0, 0, 0, 0, 0, 0, 0));
        send_request(make_req(ACT_STORE, key_a, 10, 0, 0, -262144, KIND_LOWER, 0, 0, 0));
        send_request(make_req(ACT_PROBE, key_a, 0, 262143, -262144, 0, 0, 0, 0, 0));
        send_request(make_req(ACT_PROBE, key_a, 0, 0, -262143, 0, 0, 0, 0, 0));
        send_request(make_req(ACT_STORE, key_a, 127, 0, 0, 0, KIND_UPPER, 12, 34, 9));
        send_request(make_req(ACT_PROBE, key_a, 127, 0, 0, 0, 0, 0, 0, 0));
        send_request(make_req(ACT_PROBE, key_a, 127, -1, 0, 0, 0, 0, 0, 0));
        // different hash replaces a deeper entry; bound kind three never usable
        send_request(make_req(ACT_STORE, key_b, 0, 0, 0, 5, 3, 7, 8, 1));
        send_request(make_req(ACT_PROBE, key_b, 0, 262143, -262144, 0, 0, 0, 0, 0));
        send_request(make_req(ACT_PROBE, key_a, 0, 0, 0, 0, 0, 0, 0, 0));
        send_request(make_req(ACT_STORE, '1, 127, -262144, 262143, -1, KIND_EXACT,
                              63, 0, 15));
        send_request(make_req(ACT_PROBE, '1, 127, 262143, -262144, 0, 0, 0, 0, 0));
        send_request(make_req(ACT_STORE, '1, 126, 0, 0, 1, KIND_LOWER, 0, 63, 0));
        send_request(make_req(ACT_STORE, 64'd0, 0, 0, 0, 262143, KIND_LOWER, 5, 6, 7));
        send_request(make_req(ACT_PROBE, 64'd0, 0, 0, 262143, 0, 0, 0, 0, 0));

        for (int p = 0; p < 8; p++) begin
            src_idle_pct  = idle_mix[$urandom_range(0, 3)];
            sink_idle_pct = idle_mix[$urandom_range(0, 3)];
            if (p == 2) begin
                src_idle_pct = 0;
                hold_sink    = 1'b1;
            end
            repeat (160) send_request(random_req());
        end
        i_s_axis_tvalid <= 1'b0;

        while (shadow.pending() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (shadow.mismatches == 0 && shadow.pending() == 0)
            $display("search_transposition_table: match");
        else
            $display("search_transposition_table: mismatch");
        $finish;
    end

    initial begin : watchdog
        #25_000_000;
        $display("search_transposition_table: mismatch");
        $finish;
    end

endmodule
